// File: sv/assert_macros.svh
// Assertion macros used by the biquad multiplier module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CBQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/cbq_pkg.sv
// Shared types and constants for the cascaded biquad filter.
package cbq_pkg;

  // Data path widths.
  localparam int ACC_W      = 32;
  localparam int COEF_W     = 16;
  localparam int SAMPLE_W   = 16;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = COEF_W / DIGIT_W;
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);

  // Feedback scaling shift and output saturation limit.
  localparam int FB_SHIFT = 6;
  localparam logic signed [ACC_W-1:0] CLAMP_POS = 32'sd16000;
  localparam logic signed [ACC_W-1:0] CLAMP_NEG = -32'sd16000;

  // Fixed feedforward coefficients of the second section.
  localparam logic signed [COEF_W-1:0] SEC_TWO_B_ZERO = 16'sd1;
  localparam logic signed [COEF_W-1:0] SEC_TWO_B_ONE  = 16'sd0;
  localparam logic signed [COEF_W-1:0] SEC_TWO_B_TWO  = -16'sd1;

  // Configuration register indexes.
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_S1_B0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_S1_B1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_S1_B2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_S1_A1 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_S1_A2 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_S2_A1 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_S2_A2 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_CLAMP = 3'd7;
  localparam int PADDR_W = REG_IDX_W + 2;

  // Register file contents seen by the data path.
  typedef struct packed {
    logic signed [COEF_W-1:0] s1_b0;
    logic signed [COEF_W-1:0] s1_b1;
    logic signed [COEF_W-1:0] s1_b2;
    logic signed [COEF_W-1:0] s1_a1;
    logic signed [COEF_W-1:0] s1_a2;
    logic signed [COEF_W-1:0] s2_a1;
    logic signed [COEF_W-1:0] s2_a2;
    logic                     clamp_en;
  } cbq_cfg_t;

  // Request into the serial multiplier.
  typedef struct packed {
    logic              start;
    logic [ACC_W-1:0]  mcand;
    logic [COEF_W-1:0] coef;
  } mac_req_t;

  // Result from the serial multiplier.
  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] prod;
  } mac_res_t;

endpackage

// File: sv/cascaded_biquad_with_clamp_unit.sv
// Two cascaded biquad sections with output clamp, on a shared digit-serial multiplier.
// A new beat is taken only in the idle state, once the last item has left the output
// state; in_stall is high while an item is at work. Each item runs ten products through
// the single 4-bit digit-serial multiplier, each a load state and a run of four digit
// steps, then the section states and the output state, which waits while out_stall holds.
// Reset (rst_n low, synchronous) clears the delay lines, the state, the configuration registers and output valid.
module cascaded_biquad_with_clamp_unit import cbq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ACC_W-1:0]    out_filtered,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_RUN  = 3'd2;
  localparam logic [2:0] ST_S1   = 3'd3;
  localparam logic [2:0] ST_S2   = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  // Product steps, in order.
  localparam logic [3:0] OP_X0 = 4'd0;
  localparam logic [3:0] OP_X1 = 4'd1;
  localparam logic [3:0] OP_X2 = 4'd2;
  localparam logic [3:0] OP_M1 = 4'd3;
  localparam logic [3:0] OP_M2 = 4'd4;
  localparam logic [3:0] OP_S0 = 4'd5;
  localparam logic [3:0] OP_S1 = 4'd6;
  localparam logic [3:0] OP_S2 = 4'd7;
  localparam logic [3:0] OP_Y1 = 4'd8;
  localparam logic [3:0] OP_Y2 = 4'd9;

  cbq_cfg_t cfg;
  mac_req_t mac_req;
  mac_res_t mac_res;

  logic [2:0]                state_r;
  logic [3:0]                op_r;
  logic [SAMPLE_W-1:0]       x_r;
  logic [SAMPLE_W-1:0]       x1_r;
  logic [SAMPLE_W-1:0]       x2_r;
  logic [ACC_W-1:0]          m1_r;
  logic [ACC_W-1:0]          m2_r;
  logic [ACC_W-1:0]          y1_r;
  logic [ACC_W-1:0]          y2_r;
  logic [ACC_W-1:0]          s1_r;
  logic [ACC_W-1:0]          y_r;
  logic [ACC_W-1:0]          ff_r;
  logic [ACC_W-1:0]          fb_r;
  logic                      out_valid_r;
  logic [ACC_W-1:0]          out_data_r;
  logic [ACC_W-1:0]          sec_res;
  logic [ACC_W-1:0]          clamped;
  logic                      to_fb;
  logic                      in_acc;
  logic                      out_free;

  cbq_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cbq_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .res   (mac_res)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Operand selection for the current product step.
  always_comb begin
    mac_req.start = (state_r == ST_LOAD);
    to_fb         = 1'b0;
    unique case (op_r)
      OP_X0: begin
        mac_req.mcand = ACC_W'(x_r);
        mac_req.coef  = cfg.s1_b0;
      end
      OP_X1: begin
        mac_req.mcand = ACC_W'(x1_r);
        mac_req.coef  = cfg.s1_b1;
      end
      OP_X2: begin
        mac_req.mcand = ACC_W'(x2_r);
        mac_req.coef  = cfg.s1_b2;
      end
      OP_M1: begin
        mac_req.mcand = m1_r;
        mac_req.coef  = cfg.s1_a1;
        to_fb         = 1'b1;
      end
      OP_M2: begin
        mac_req.mcand = m2_r;
        mac_req.coef  = cfg.s1_a2;
        to_fb         = 1'b1;
      end
      OP_S0: begin
        mac_req.mcand = s1_r;
        mac_req.coef  = SEC_TWO_B_ZERO;
      end
      OP_S1: begin
        mac_req.mcand = m1_r;
        mac_req.coef  = SEC_TWO_B_ONE;
      end
      OP_S2: begin
        mac_req.mcand = m2_r;
        mac_req.coef  = SEC_TWO_B_TWO;
      end
      OP_Y1: begin
        mac_req.mcand = y1_r;
        mac_req.coef  = cfg.s2_a1;
        to_fb         = 1'b1;
      end
      OP_Y2: begin
        mac_req.mcand = y2_r;
        mac_req.coef  = cfg.s2_a2;
        to_fb         = 1'b1;
      end
      default: begin
        mac_req.mcand = '0;
        mac_req.coef  = '0;
      end
    endcase
  end

  // Section output: feedforward sum minus the scaled feedback sum.
  assign sec_res = ff_r - ACC_W'($signed(fb_r) >>> FB_SHIFT);

  // Output saturation when clamping is enabled.
  always_comb begin
    priority if (cfg.clamp_en && ($signed(y_r) > CLAMP_POS)) begin
      clamped = CLAMP_POS;
    end else if (cfg.clamp_en && ($signed(y_r) < CLAMP_NEG)) begin
      clamped = CLAMP_NEG;
    end else begin
      clamped = y_r;
    end
  end

  // Sequencer and filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_X0;
      out_valid_r <= 1'b0;
      x1_r        <= '0;
      x2_r        <= '0;
      m1_r        <= '0;
      m2_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
    end else begin
      // A new result beat is raised on leaving the output state; an accepted one drops.
      if ((state_r == ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            op_r    <= OP_X0;
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state_r <= ST_RUN;
        end
        ST_RUN: begin
          if (mac_res.done) begin
            priority if (op_r == OP_M2) begin
              state_r <= ST_S1;
            end else if (op_r == OP_Y2) begin
              state_r <= ST_S2;
            end else begin
              op_r    <= op_r + 1'b1;
              state_r <= ST_LOAD;
            end
          end
        end
        ST_S1: begin
          op_r    <= OP_S0;
          state_r <= ST_LOAD;
        end
        ST_S2: begin
          // Shift every delay line by one item.
          x2_r    <= x1_r;
          x1_r    <= x_r;
          m2_r    <= m1_r;
          m1_r    <= s1_r;
          y2_r    <= y1_r;
          y1_r    <= sec_res;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Data path registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r  <= in_sample;
      ff_r <= '0;
      fb_r <= '0;
    end else if ((state_r == ST_RUN) && mac_res.done) begin
      if (to_fb) begin
        fb_r <= fb_r + mac_res.prod;
      end else begin
        ff_r <= ff_r + mac_res.prod;
      end
    end else if (state_r == ST_S1) begin
      s1_r <= sec_res;
      ff_r <= '0;
      fb_r <= '0;
    end
    if (state_r == ST_S2) begin
      y_r <= sec_res;
    end
    if ((state_r == ST_OUT) && out_free) begin
      out_data_r <= clamped;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_data_r;

endmodule

// File: sv/cbq_mac.sv
// Digit-serial multiplier: 32-bit multiplicand times 16-bit signed coefficient, mod 2^32.
`include "assert_macros.svh"

module cbq_mac import cbq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mac_req_t req,
  output mac_res_t res
);

  logic                         busy_r;
  logic                         done_r;
  logic [DIG_CNT_W-1:0]         cnt_r;
  logic [ACC_W-1:0]             mcand_r;
  logic [COEF_W-1:0]            coef_r;
  logic [ACC_W-1:0]             prod_r;
  logic [ACC_W-1:0]             prod_nxt;
  logic                         last;
  logic signed [DIGIT_W:0]      dig_s;
  logic signed [ACC_W+DIGIT_W:0] pp;

  // The top digit carries the coefficient sign; the lower digits are unsigned.
  assign dig_s = (cnt_r == '0) ?
                 $signed({coef_r[COEF_W-1], coef_r[COEF_W-1 -: DIGIT_W]}) :
                 $signed({1'b0, coef_r[COEF_W-1 -: DIGIT_W]});

  // Horner step, most significant digit first: prod = prod * 16 + mcand * digit.
  assign pp       = $signed(mcand_r) * dig_s;
  assign prod_nxt = {prod_r[ACC_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + pp[ACC_W-1:0];
  assign last     = (cnt_r == DIG_CNT_W'(NUM_DIGITS - 1));

  // Control: a start runs NUM_DIGITS steps and then pulses done.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Operand and partial product shift registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand_r <= req.mcand;
      coef_r  <= req.coef;
      prod_r  <= '0;
    end else if (busy_r) begin
      prod_r <= prod_nxt;
      coef_r <= {coef_r[COEF_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  assign res.done = done_r;
  assign res.prod = prod_r;

  `CBQ_ASSERT_IMPL(a_no_restart, req.start, !busy_r, "multiplier started while busy")
  `CBQ_ASSERT_IMPL(a_done_idle, done_r, !busy_r, "done raised while still busy")
  `CBQ_ASSERT_NEXT(a_done_follows, busy_r && last, done_r, "last digit did not give done")

endmodule

// File: sv/cbq_regs.sv
// APB-style configuration registers for the biquad coefficients and clamp enable.
module cbq_regs import cbq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cbq_cfg_t           cfg
);

  cbq_cfg_t               cfg_r;
  logic [REG_IDX_W-1:0]   idx;
  logic                   wr_en;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes on the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_S1_B0: cfg_r.s1_b0    <= pwdata[COEF_W-1:0];
        REG_S1_B1: cfg_r.s1_b1    <= pwdata[COEF_W-1:0];
        REG_S1_B2: cfg_r.s1_b2    <= pwdata[COEF_W-1:0];
        REG_S1_A1: cfg_r.s1_a1    <= pwdata[COEF_W-1:0];
        REG_S1_A2: cfg_r.s1_a2    <= pwdata[COEF_W-1:0];
        REG_S2_A1: cfg_r.s2_a1    <= pwdata[COEF_W-1:0];
        REG_S2_A2: cfg_r.s2_a2    <= pwdata[COEF_W-1:0];
        REG_CLAMP: cfg_r.clamp_en <= pwdata[0];
        default:   cfg_r          <= cfg_r;
      endcase
    end
  end

  // Read back, coefficients sign extended.
  always_comb begin
    unique case (idx)
      REG_S1_B0: prdata = 32'(cfg_r.s1_b0);
      REG_S1_B1: prdata = 32'(cfg_r.s1_b1);
      REG_S1_B2: prdata = 32'(cfg_r.s1_b2);
      REG_S1_A1: prdata = 32'(cfg_r.s1_a1);
      REG_S1_A2: prdata = 32'(cfg_r.s1_a2);
      REG_S2_A1: prdata = 32'(cfg_r.s2_a1);
      REG_S2_A2: prdata = 32'(cfg_r.s2_a2);
      REG_CLAMP: prdata = {31'd0, cfg_r.clamp_en};
      default:   prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the cascaded biquad filter with output clamp.
`timescale 1ns / 100ps

module testbench;
  import cbq_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_BEATS = 128;

  // Block ports; the inputs are all known from time zero.
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ACC_W-1:0]    out_filtered;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Filter predictor: register copies and delay lines.
  logic signed [COEF_W-1:0] s1_b0, s1_b1, s1_b2, s1_a1, s1_a2, s2_a1, s2_a2;
  logic                     clamp_on;
  logic [SAMPLE_W-1:0]      smp_d1, smp_d2;
  logic [ACC_W-1:0]         sec1_d1, sec1_d2, sec2_d1, sec2_d2;

  logic [ACC_W-1:0] expected_filtered[$];
  int               error_count = 0;
  int               cycle_count = 0;
  int               hold_left = 0;
  bit               idle_on = 1'b0;

  cascaded_biquad_with_clamp_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_filtered(out_filtered),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Run length guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sign-extend a coefficient to the accumulator width.
  function automatic logic [ACC_W-1:0] widen(input logic [COEF_W-1:0] c);
    return {{(ACC_W-COEF_W){c[COEF_W-1]}}, c};
  endfunction

  // Runs one sample through both sections; all sums wrap at 32 bits.
  function automatic logic [ACC_W-1:0] filter_sample(input logic [SAMPLE_W-1:0] x);
    logic [ACC_W-1:0]        ff, fb, s1, y;
    logic signed [ACC_W-1:0] fb_scaled;
    ff = widen(s1_b0) * {16'b0, x} + widen(s1_b1) * {16'b0, smp_d1}
       + widen(s1_b2) * {16'b0, smp_d2};
    smp_d2 = smp_d1;
    smp_d1 = x;
    fb = widen(s1_a1) * sec1_d1 + widen(s1_a2) * sec1_d2;
    fb_scaled = $signed(fb) >>> FB_SHIFT;
    s1 = ff - fb_scaled;

    ff = s1 * widen(SEC_TWO_B_ZERO) + sec1_d1 * widen(SEC_TWO_B_ONE)
       + sec1_d2 * widen(SEC_TWO_B_TWO);
    sec1_d2 = sec1_d1;
    sec1_d1 = s1;
    fb = widen(s2_a1) * sec2_d1 + widen(s2_a2) * sec2_d2;
    fb_scaled = $signed(fb) >>> FB_SHIFT;
    y = ff - fb_scaled;
    sec2_d2 = sec2_d1;
    sec2_d1 = y;

    // The delays keep the unclamped value; only the result saturates.
    if (clamp_on) begin
      if ($signed(y) > CLAMP_POS) begin
        y = CLAMP_POS;
      end else if ($signed(y) < CLAMP_NEG) begin
        y = CLAMP_NEG;
      end
    end
    return y;
  endfunction

  // Value a register should read back, in its own width.
  function automatic logic [31:0] reg_contents(input logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_S1_B0: return {16'b0, s1_b0};
      REG_S1_B1: return {16'b0, s1_b1};
      REG_S1_B2: return {16'b0, s1_b2};
      REG_S1_A1: return {16'b0, s1_a1};
      REG_S1_A2: return {16'b0, s1_a2};
      REG_S2_A1: return {16'b0, s2_a1};
      REG_S2_A2: return {16'b0, s2_a2};
      default:   return {31'b0, clamp_on};
    endcase
  endfunction

  // Coefficient draw weighted toward the extremes and small values.
  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'($signed($urandom_range(0, 128)) - 64);
      default: return 16'($urandom());
    endcase
  endfunction

  // Writes one register, then reads it back.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
    logic [31:0] got;
    logic [31:0] want;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{16{value[COEF_W-1]}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_S1_B0: s1_b0 = value;
      REG_S1_B1: s1_b1 = value;
      REG_S1_B2: s1_b2 = value;
      REG_S1_A1: s1_a1 = value;
      REG_S1_A2: s1_a2 = value;
      REG_S2_A1: s2_a1 = value;
      REG_S2_A2: s2_a2 = value;
      default:   clamp_on = value[0];
    endcase

    // Read back through the same port.
    @(posedge clk);
    psel <= 1'b1;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    want = reg_contents(idx);
    if ((idx == REG_CLAMP && got[0] != want[0]) ||
        (idx != REG_CLAMP && got[COEF_W-1:0] != want[COEF_W-1:0])) begin
      $display("%0t: register %0d read back expected %h, actual %h", $time, idx, want, got);
      error_count++;
    end
  endtask

  task automatic write_all(input logic [COEF_W-1:0] b0, b1, b2, a1, a2, c1, c2,
                           input bit clamp);
    write_reg(REG_S1_B0, b0);
    write_reg(REG_S1_B1, b1);
    write_reg(REG_S1_B2, b2);
    write_reg(REG_S1_A1, a1);
    write_reg(REG_S1_A2, a2);
    write_reg(REG_S2_A1, c1);
    write_reg(REG_S2_A2, c2);
    write_reg(REG_CLAMP, {15'b0, clamp});
  endtask

  // Sends one sample beat; valid stays high into the next call when no gap is drawn.
  task automatic send_sample(input logic [SAMPLE_W-1:0] x);
    int gap;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= x;
    do @(posedge clk); while (in_stall);
    expected_filtered.push_back(filter_sample(x));
  endtask

  // Lowers valid and waits for every outstanding result.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_filtered.size() != 0) @(posedge clk);
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_filtered.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_filtered);
          error_count++;
        end else begin
          if (out_filtered !== expected_filtered[0]) begin
            $display("%0t: filtered mismatch, expected %h, actual %h",
                     $time, expected_filtered[0], out_filtered);
            error_count++;
          end
          void'(expected_filtered.pop_front());
        end
        hold_left = idle_on ? $urandom_range(0, 12) : 0;
        out_stall <= (hold_left != 0);
      end else if (out_valid && out_stall) begin
        hold_left = hold_left - 1;
        out_stall <= (hold_left > 0);
      end
    end
  end

  // With all coefficients at reset the output stays at zero.
  task automatic test_reset_state();
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    drain();
  endtask

  // Feedforward products at the coefficient extremes wrap at 32 bits.
  task automatic test_feedforward_wrap();
    write_all(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_sample(16'hFFFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h0000);
    send_sample(16'h0001);
    drain();
  endtask

  // Feedback at the extremes exercises the arithmetic shift of negative sums.
  task automatic test_feedback_extremes();
    write_all(16'h0001, 16'h0001, 16'h0001, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    drain();
  endtask

  // Pass-through first section: values at and just past the clamp limits,
  // then a large product that must saturate while the delays keep it.
  task automatic test_clamp_limits();
    write_all(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_sample(16'd0);
    send_sample(16'd0);
    send_sample(16'd16000);
    send_sample(16'd0);
    send_sample(16'd0);
    send_sample(16'd16001);
    send_sample(16'd0);
    send_sample(16'd0);
    drain();
    write_reg(REG_S1_B0, 16'h7FFF);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    drain();
  endtask

  // Random configurations, each followed by a run of random samples.
  task automatic test_random_phases();
    logic [SAMPLE_W-1:0] x;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_on = (phase % 3 != 2);
      write_all(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                pick_coef(), pick_coef(), 1'($urandom_range(0, 1)));
      for (int n = 0; n < PHASE_BEATS; n++) begin
        case ($urandom_range(0, 9))
          0:       x = 16'hFFFF;
          1:       x = 16'h0000;
          2:       x = 16'($urandom_range(0, 255));
          default: x = 16'($urandom());
        endcase
        send_sample(x);
      end
      drain();
    end
  endtask

  initial begin
    {s1_b0, s1_b1, s1_b2, s1_a1, s1_a2, s2_a1, s2_a2} = '0;
    clamp_on = 1'b0;
    {smp_d1, smp_d2} = '0;
    {sec1_d1, sec1_d2, sec2_d1, sec2_d2} = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_on = 1'b1;
    test_reset_state();
    test_feedforward_wrap();
    test_feedback_extremes();
    test_clamp_limits();
    test_random_phases();

    repeat (80) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/cbq_pkg.sv
sv/cbq_mac.sv
sv/cbq_regs.sv
sv/cascaded_biquad_with_clamp_unit.sv
verif/testbench.sv
